FILE: hdl/rhh_pkg.sv
// Shared types, constants and hash helpers for the Robin Hood hash table.
// No dependencies; every other file uses this package by scoped names.
`timescale 1ns / 1ps
package rhh_pkg;

  localparam int SLOTS = 256;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int KEY_W = 64;
  localparam int VAL_W = 32;
  localparam int DIST_W = IDX_W;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key_bytes;
    logic [VAL_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [VAL_W-1:0] value_out;
  } out_t;

  // Classified request handed from the front end to the probe engine.
  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] home;
  } job_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [DIST_W-1:0] pdist;
  } entry_t;

  // Clear everything from the first zero byte upward.
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    logic             live;
    k = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (raw[8*b +: 8] == 8'd0) live = 1'b0;
      if (live) k[8*b +: 8] = raw[8*b +: 8];
    end
    return k;
  endfunction

  // One FNV-1 round: multiply by 2^40 + 0x1b3 (shift-add), then xor the byte.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] p;
    p = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
    return p ^ {56'd0, b};
  endfunction

endpackage

FILE: hdl/robin_hood_hash_table.sv
// Top level of the Robin Hood hash table: front end, job queue and probe engine.
// Depends on rhh_pkg, rhh_front, rhh_queue and rhh_back.
`timescale 1ns / 1ps
// Usage:
//   A transaction is taken at a rising edge where start is high and busy is low.
//   in_item.mode selects insert/update (0) or lookup (1); in_item.key_bytes holds
//   up to eight key bytes, first byte lowest, ending at the first zero byte.
//   Each transaction yields one result on out_item, valid for exactly one cycle
//   while done is high; the receiver cannot stall, so results are never held.
//   Flow: the front end hashes one byte per cycle and then hands the job to the
//   queue; the probe engine picks up the job, then for each slot visited reads
//   the slot memory and then compares and, if needed, writes the slot.
//   Throughput: a two-entry queue lets the front end hash the next transaction
//   while the probe engine walks the previous one; the probe chain length sets
//   the sustained rate.
//   Reset (rst, synchronous) clears all slot valid bits and the entry count at
//   once; the slot memory itself is not cleared and needs no sweep.
module robin_hood_hash_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rhh_pkg::in_t  in_item,
  output logic          done,
  output rhh_pkg::out_t out_item
);

  rhh_pkg::job_t f_job;
  rhh_pkg::job_t q_job;
  logic          push;
  logic          full;
  logic          pop;
  logic          empty;

  // hash stage
  rhh_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .push    (push),
    .job     (f_job),
    .full    (full)
  );

  // decouples hashing from probing; keeps transaction order
  rhh_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (f_job),
    .full   (full),
    .pop    (pop),
    .rd_job (q_job),
    .empty  (empty)
  );

  // probe and displacement engine with the slot store
  rhh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .q_job    (q_job),
    .pop      (pop),
    .done     (done),
    .out_item (out_item)
  );

endmodule

FILE: hdl/rhh_front.sv
// Front end: takes a transaction, normalizes the key and hashes it a byte per cycle.
// Depends on rhh_pkg; feeds rhh_queue.
`timescale 1ns / 1ps
module rhh_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rhh_pkg::in_t  in_item,
  output logic          push,
  output rhh_pkg::job_t job,
  input  logic          full
);

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_PUSH} state_t;

  state_t      state;
  logic [2:0]  idx;
  logic [63:0] h;
  logic [63:0] h_next;
  logic [7:0]  cur;

  assign busy   = (state != S_IDLE);
  assign push   = (state == S_PUSH) && !full;
  assign cur    = job.key[{idx, 3'b000} +: 8];
  assign h_next = rhh_pkg::fnv_step(h, cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            job.mode  <= in_item.mode;
            job.key   <= rhh_pkg::norm_key(in_item.key_bytes);
            job.value <= in_item.value_in;
            h         <= rhh_pkg::FNV_BASIS;
            idx       <= '0;
            state     <= S_HASH;
          end
        end
        S_HASH: begin
          if (cur == 8'd0) begin
            job.home <= h[rhh_pkg::IDX_W-1:0];
            state    <= S_PUSH;
          end else begin
            h   <= h_next;
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              job.home <= h_next[rhh_pkg::IDX_W-1:0];
              state    <= S_PUSH;
            end
          end
        end
        S_PUSH: begin
          if (!full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/rhh_queue.sv
// Two-entry queue of hashed jobs between the front end and the probe engine.
// Depends on rhh_pkg.
`timescale 1ns / 1ps
module rhh_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rhh_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output rhh_pkg::job_t rd_job,
  output logic          empty
);

  rhh_pkg::job_t slots [2];
  logic          wp;
  logic          rp;
  logic [1:0]    fill;

  assign full   = (fill == 2'd2);
  assign empty  = (fill == 2'd0);
  assign rd_job = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: hdl/rhh_back.sv
// Probe engine: slot memory, valid bits and the Robin Hood insert/lookup sequencer.
// Depends on rhh_pkg; pops jobs from rhh_queue.
`timescale 1ns / 1ps
module rhh_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  rhh_pkg::job_t q_job,
  output logic          pop,
  output logic          done,
  output rhh_pkg::out_t out_item
);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EXAM} state_t;
  typedef enum logic [1:0] {M_FIND, M_INS, M_DISP} mode_t;

  rhh_pkg::entry_t mem [rhh_pkg::SLOTS];
  rhh_pkg::entry_t rdata;
  rhh_pkg::entry_t wentry;
  rhh_pkg::entry_t carry;
  rhh_pkg::job_t   job;

  logic [rhh_pkg::SLOTS-1:0]  valid;
  logic [rhh_pkg::CNT_W-1:0]  count;
  logic [rhh_pkg::CNT_W-1:0]  n;
  logic [rhh_pkg::IDX_W-1:0]  addr;
  logic [rhh_pkg::DIST_W-1:0] probe_dist;
  state_t                     state;
  mode_t                      mode;
  logic                       we;
  logic                       vld;
  logic                       hit;

  assign pop = (state == S_IDLE) && !empty;
  assign vld = valid[addr];
  assign hit = vld && (rdata.key == job.key);

  always_comb begin
    we     = 1'b0;
    wentry = rdata;
    if (state == S_EXAM) begin
      unique case (mode)
        M_FIND: begin
          if (hit && job.mode == rhh_pkg::MODE_INSERT) begin
            we           = 1'b1;
            wentry.value = job.value;
          end
        end
        M_INS: begin
          if (hit) begin
            we           = 1'b1;
            wentry.value = job.value;
          end else if (!vld || rdata.pdist < probe_dist) begin
            we     = 1'b1;
            wentry = '{key: job.key, value: job.value, pdist: probe_dist};
          end
        end
        M_DISP: begin
          if (!vld || rdata.pdist < carry.pdist) begin
            we     = 1'b1;
            wentry = carry;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wentry;
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            job        <= q_job;
            addr       <= q_job.home;
            probe_dist <= '0;
            n          <= '0;
            if (q_job.mode == rhh_pkg::MODE_LOOKUP || count == rhh_pkg::CNT_W'(rhh_pkg::SLOTS))
              mode <= M_FIND;
            else
              mode <= M_INS;
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_EXAM;
        S_EXAM: begin
          state <= S_FETCH;
          unique case (mode)
            M_FIND: begin
              if (hit) begin
                done  <= 1'b1;
                state <= S_IDLE;
                if (job.mode == rhh_pkg::MODE_LOOKUP)
                  out_item <= '{status: rhh_pkg::ST_FOUND, value_out: rdata.value};
                else
                  out_item <= '{status: rhh_pkg::ST_UPDATED, value_out: '0};
              end else if (!vld || n == rhh_pkg::CNT_W'(rhh_pkg::SLOTS - 1)) begin
                done  <= 1'b1;
                state <= S_IDLE;
                out_item <= '{status: (job.mode == rhh_pkg::MODE_LOOKUP) ?
                              rhh_pkg::ST_NOT_FOUND : rhh_pkg::ST_FULL, value_out: '0};
              end else begin
                n    <= n + rhh_pkg::CNT_W'(1);
                addr <= addr + rhh_pkg::IDX_W'(1);
              end
            end
            M_INS: begin
              if (!vld) begin
                valid[addr] <= 1'b1;
                count       <= count + rhh_pkg::CNT_W'(1);
                done        <= 1'b1;
                state       <= S_IDLE;
                out_item    <= '{status: rhh_pkg::ST_INSERTED, value_out: '0};
              end else if (hit) begin
                done     <= 1'b1;
                state    <= S_IDLE;
                out_item <= '{status: rhh_pkg::ST_UPDATED, value_out: '0};
              end else if (rdata.pdist < probe_dist) begin
                // new key settles here; the evicted entry moves on one slot further
                count <= count + rhh_pkg::CNT_W'(1);
                carry <= '{key: rdata.key, value: rdata.value,
                           pdist: rdata.pdist + rhh_pkg::DIST_W'(1)};
                mode  <= M_DISP;
                addr  <= addr + rhh_pkg::IDX_W'(1);
              end else begin
                probe_dist <= probe_dist + rhh_pkg::DIST_W'(1);
                addr       <= addr + rhh_pkg::IDX_W'(1);
              end
            end
            M_DISP: begin
              if (!vld) begin
                valid[addr] <= 1'b1;
                done        <= 1'b1;
                state       <= S_IDLE;
                out_item    <= '{status: rhh_pkg::ST_INSERTED, value_out: '0};
              end else begin
                if (rdata.pdist < carry.pdist) begin
                  carry <= '{key: rdata.key, value: rdata.value,
                             pdist: rdata.pdist + rhh_pkg::DIST_W'(1)};
                end else begin
                  carry.pdist <= carry.pdist + rhh_pkg::DIST_W'(1);
                end
                addr <= addr + rhh_pkg::IDX_W'(1);
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
